/* sv/time_of_day_counter_with_delays_core_macros.svh */
// Assertion macros for the time-of-day counter core.
// Used by time_of_day_counter_with_delays_core.sv; expects clk and rst_n in scope.
`ifndef TIME_OF_DAY_COUNTER_WITH_DELAYS_CORE_MACROS_SVH
`define TIME_OF_DAY_COUNTER_WITH_DELAYS_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TOD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TOD_ASSERT(lbl, ante, cons, msg)
`define TOD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/tod_pkg.sv */
// Types, constants and digit helpers for the time-of-day counter core.
// No dependencies.
`default_nettype none

package tod_pkg;

  localparam int unsigned TOD_DELAY_CHANNELS = 16;
  localparam int unsigned TOD_CHX_W          = 7;   // holds any channel count up to 127

  localparam int unsigned TOD_SEC_W  = 17;
  localparam int unsigned TOD_HOUR_W = 5;
  localparam int unsigned TOD_MIN_W  = 6;
  localparam int unsigned TOD_CHAR_W = 6;

  localparam logic [TOD_SEC_W-1:0]  TOD_LAST_SECOND   = 17'd86399;
  localparam logic [TOD_SEC_W:0]    TOD_DAY_LENGTH    = 18'd86400;
  localparam logic [TOD_SEC_W:0]    TOD_TWO_DAYS      = 18'd172800;
  localparam logic [TOD_SEC_W-1:0]  TOD_SECS_PER_HOUR = 17'd3600;
  localparam logic [TOD_SEC_W-1:0]  TOD_SECS_PER_MIN  = 17'd60;
  localparam logic [TOD_HOUR_W-1:0] TOD_LAST_HOUR     = 5'd23;
  localparam logic [TOD_MIN_W-1:0]  TOD_LAST_MIN      = 6'd59;
  localparam logic [7:0]            TOD_HOURS_PER_DAY = 8'd24;
  localparam logic [7:0]            TOD_MINS_PER_HOUR = 8'd60;
  localparam logic [TOD_CHAR_W-1:0] TOD_ASCII_ZERO    = 6'd48;

  typedef enum logic [1:0] {
    OP_TICK_UP   = 2'd0,
    OP_TICK_DOWN = 2'd1,
    OP_PRESET    = 2'd2,
    OP_POLL      = 2'd3
  } tod_op_t;

  typedef struct packed {
    tod_op_t               opcode;
    logic [7:0]            set_hour;
    logic [7:0]            set_minute;
    logic [7:0]            set_second;
    logic [3:0]            channel;
    logic [TOD_SEC_W-1:0]  delay_seconds;
  } tod_in_t;

  typedef struct packed {
    logic [TOD_SEC_W-1:0]  seconds_now;
    logic [TOD_HOUR_W-1:0] hour_now;
    logic [TOD_MIN_W-1:0]  minute_now;
    logic [TOD_MIN_W-1:0]  second_now;
    logic [TOD_CHAR_W-1:0] hour_tens_char;
    logic [TOD_CHAR_W-1:0] hour_ones_char;
    logic [TOD_CHAR_W-1:0] minute_tens_char;
    logic [TOD_CHAR_W-1:0] minute_ones_char;
    logic [TOD_CHAR_W-1:0] second_tens_char;
    logic [TOD_CHAR_W-1:0] second_ones_char;
    logic                  delay_fired;
  } tod_out_t;

  // tens digit of a value below 60
  function automatic logic [2:0] tens_of(input logic [5:0] v);
    logic [2:0] t;
    priority if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [TOD_CHAR_W-1:0] tens_char(input logic [5:0] v);
    return TOD_ASCII_ZERO + TOD_CHAR_W'(tens_of(v));
  endfunction

  function automatic logic [TOD_CHAR_W-1:0] ones_char(input logic [5:0] v);
    logic [5:0] r;
    r = v - 6'(tens_of(v)) * 6'd10;
    return TOD_ASCII_ZERO + r;
  endfunction

endpackage

`default_nettype wire

/* sv/time_of_day_counter_with_delays_core.sv */
// Seconds-of-day counter with one-shot delay channels: top level.
// Depends on tod_pkg and time_of_day_counter_with_delays_core_macros.svh.
//
// Usage:
//   Requests come in on in_valid/in_stall/in_data (tod_in_t): tick up, tick
//   down, preset from hour/minute/second, or poll/arm a delay channel.
//   Every request gives exactly one result on out_valid/out_stall/out_data
//   (tod_out_t): the time after the request, its fields, six ASCII digits
//   and the fired flag of a poll.
//   With no stall a request passes the request register and then the result
//   register, which drives out_valid. The block takes one request per cycle
//   while in_stall is low; the limit is the update of the time registers
//   and one channel's armed bit and target per request.
//   Targets live in a DELAY_CHANNELS-deep memory read when a request is
//   accepted; a write by the request ahead is forwarded to that read.
//   A request register in front of the result register lets one more
//   request in while a result waits; after that in_stall rises until
//   out_stall drops.
//   Reset sets the time to midnight and disarms every channel. Targets are
//   not cleared; they are only used while their channel is armed.
`default_nettype none

`include "time_of_day_counter_with_delays_core_macros.svh"

module time_of_day_counter_with_delays_core #(
  parameter int unsigned DELAY_CHANNELS = tod_pkg::TOD_DELAY_CHANNELS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tod_pkg::tod_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tod_pkg::tod_out_t out_data
);
  import tod_pkg::*;

  localparam int unsigned CH_W = (DELAY_CHANNELS > 1) ? $clog2(DELAY_CHANNELS) : 1;

  // request stage
  logic                 req_valid_r;
  tod_in_t              req_r;
  logic [CH_W-1:0]      req_idx_r;
  logic                 req_ok_r;
  logic [TOD_SEC_W-1:0] tgt_rd_r;

  // state
  logic [TOD_SEC_W-1:0]      day_sec_r, day_sec_nxt;
  logic [TOD_HOUR_W-1:0]     hour_r, hour_nxt;
  logic [TOD_MIN_W-1:0]      minute_r, minute_nxt;
  logic [TOD_MIN_W-1:0]      second_r, second_nxt;
  logic [DELAY_CHANNELS-1:0] armed_r, armed_nxt;
  logic [TOD_SEC_W-1:0]      tgt_mem [DELAY_CHANNELS];

  // result stage
  logic     out_valid_r;
  tod_out_t out_data_r, out_data_nxt;

  logic                 out_free, proc_go, in_go;
  logic [TOD_CHX_W-1:0] in_chx;
  logic                 in_ok;
  logic [CH_W-1:0]      in_idx;
  logic                 armed_cur, is_poll, fire, arm;
  logic [TOD_SEC_W:0]   tgt_sum;
  logic [TOD_SEC_W-1:0] tgt_wdata;
  logic                 tgt_we;
  logic [TOD_HOUR_W-1:0] ph;
  logic [TOD_MIN_W-1:0]  pm, ps;

  assign out_free = !out_valid_r || !out_stall;
  assign proc_go  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;
  assign in_go    = in_valid && !in_stall;

  assign in_chx = TOD_CHX_W'(in_data.channel);
  assign in_ok  = in_chx < TOD_CHX_W'(DELAY_CHANNELS);
  assign in_idx = in_chx[CH_W-1:0];

  // channel decision
  assign armed_cur = req_ok_r && armed_r[req_idx_r];
  assign is_poll   = (req_r.opcode == OP_POLL) && req_ok_r;
  assign fire      = is_poll && armed_cur && (day_sec_r >= tgt_rd_r);
  assign arm       = is_poll && !armed_cur;
  assign tgt_we    = proc_go && arm;

  // (now + delay) mod day; the sum stays below three days
  assign tgt_sum = (TOD_SEC_W+1)'(day_sec_r) + (TOD_SEC_W+1)'(req_r.delay_seconds);
  always_comb begin
    priority if (tgt_sum >= TOD_TWO_DAYS) begin
      tgt_wdata = TOD_SEC_W'(tgt_sum - TOD_TWO_DAYS);
    end else if (tgt_sum >= TOD_DAY_LENGTH) begin
      tgt_wdata = TOD_SEC_W'(tgt_sum - TOD_DAY_LENGTH);
    end else begin
      tgt_wdata = TOD_SEC_W'(tgt_sum);
    end
  end

  always_comb begin
    armed_nxt = armed_r;
    if (proc_go && arm) begin
      armed_nxt[req_idx_r] = 1'b1;
    end
    if (proc_go && fire) begin
      armed_nxt[req_idx_r] = 1'b0;
    end
  end

  // preset fields, each set to zero on its own when out of range
  assign ph = (req_r.set_hour < TOD_HOURS_PER_DAY) ? TOD_HOUR_W'(req_r.set_hour) : '0;
  assign pm = (req_r.set_minute < TOD_MINS_PER_HOUR) ? TOD_MIN_W'(req_r.set_minute) : '0;
  assign ps = (req_r.set_second < TOD_MINS_PER_HOUR) ? TOD_MIN_W'(req_r.set_second) : '0;

  // time update; hour/minute/second are carried alongside the count
  always_comb begin
    day_sec_nxt = day_sec_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    second_nxt  = second_r;
    unique case (req_r.opcode)
      OP_TICK_UP: begin
        if (day_sec_r == TOD_LAST_SECOND) begin
          day_sec_nxt = '0;
          hour_nxt    = '0;
          minute_nxt  = '0;
          second_nxt  = '0;
        end else begin
          day_sec_nxt = day_sec_r + 1'b1;
          if (second_r == TOD_LAST_MIN) begin
            second_nxt = '0;
            if (minute_r == TOD_LAST_MIN) begin
              minute_nxt = '0;
              hour_nxt   = hour_r + 1'b1;
            end else begin
              minute_nxt = minute_r + 1'b1;
            end
          end else begin
            second_nxt = second_r + 1'b1;
          end
        end
      end
      OP_TICK_DOWN: begin
        if (day_sec_r == '0) begin
          day_sec_nxt = TOD_LAST_SECOND;
          hour_nxt    = TOD_LAST_HOUR;
          minute_nxt  = TOD_LAST_MIN;
          second_nxt  = TOD_LAST_MIN;
        end else begin
          day_sec_nxt = day_sec_r - 1'b1;
          if (second_r == '0) begin
            second_nxt = TOD_LAST_MIN;
            if (minute_r == '0) begin
              minute_nxt = TOD_LAST_MIN;
              hour_nxt   = hour_r - 1'b1;
            end else begin
              minute_nxt = minute_r - 1'b1;
            end
          end else begin
            second_nxt = second_r - 1'b1;
          end
        end
      end
      OP_PRESET: begin
        hour_nxt    = ph;
        minute_nxt  = pm;
        second_nxt  = ps;
        day_sec_nxt = TOD_SEC_W'(ph) * TOD_SECS_PER_HOUR
                    + TOD_SEC_W'(pm) * TOD_SECS_PER_MIN + TOD_SEC_W'(ps);
      end
      OP_POLL: begin
        day_sec_nxt = day_sec_r;
      end
      default: begin
        day_sec_nxt = day_sec_r;
      end
    endcase
  end

  always_comb begin
    out_data_nxt.seconds_now      = day_sec_nxt;
    out_data_nxt.hour_now         = hour_nxt;
    out_data_nxt.minute_now       = minute_nxt;
    out_data_nxt.second_now       = second_nxt;
    out_data_nxt.hour_tens_char   = tens_char(TOD_MIN_W'(hour_nxt));
    out_data_nxt.hour_ones_char   = ones_char(TOD_MIN_W'(hour_nxt));
    out_data_nxt.minute_tens_char = tens_char(minute_nxt);
    out_data_nxt.minute_ones_char = ones_char(minute_nxt);
    out_data_nxt.second_tens_char = tens_char(second_nxt);
    out_data_nxt.second_ones_char = ones_char(second_nxt);
    out_data_nxt.delay_fired      = fire;
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      day_sec_r   <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
      armed_r     <= '0;
    end else begin
      if (in_go) begin
        req_valid_r <= 1'b1;
      end else if (proc_go) begin
        req_valid_r <= 1'b0;
      end
      if (proc_go) begin
        out_valid_r <= 1'b1;
        day_sec_r   <= day_sec_nxt;
        hour_r      <= hour_nxt;
        minute_r    <= minute_nxt;
        second_r    <= second_nxt;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      armed_r <= armed_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      req_r     <= in_data;
      req_idx_r <= in_idx;
      req_ok_r  <= in_ok;
    end
    if (proc_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  // target memory, registered read with write forwarding
  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[req_idx_r] <= tgt_wdata;
    end
    if (in_go && in_ok) begin
      if (tgt_we && (req_idx_r == in_idx)) begin
        tgt_rd_r <= tgt_wdata;
      end else begin
        tgt_rd_r <= tgt_mem[in_idx];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TOD_ASSERT(a_day_range, 1'b1, day_sec_r <= TOD_LAST_SECOND, "seconds count out of range")
  `TOD_ASSERT(a_hms_match, 1'b1,
              day_sec_r == TOD_SEC_W'(hour_r) * TOD_SECS_PER_HOUR
                         + TOD_SEC_W'(minute_r) * TOD_SECS_PER_MIN + TOD_SEC_W'(second_r),
              "h/m/s disagree with count")
  `TOD_ASSERT(a_stall_full, in_stall, req_valid_r && out_valid_r, "stall with free stage")
  `TOD_ASSERT_NEXT(a_fire_disarms, proc_go && fire, !armed_r[$past(req_idx_r)],
                   "fired channel still armed")
  `TOD_ASSERT_NEXT(a_fire_poll_only, proc_go && (req_r.opcode != OP_POLL),
                   !out_data_r.delay_fired, "fire on non-poll request")

endmodule

`default_nettype wire
